// ----- src/nca_pkg.sv -----
// Shared types, sizes and weight tables for the Newton-Cotes quadrature accumulator.
// Used by newton_cotes_quadrature_accumulator; depends on nothing else.
`default_nettype none
package nca_pkg;

	localparam int unsigned MAX_POINTS = 4096;
	localparam int unsigned CNT_W      = 13;
	localparam int unsigned POS_W      = $clog2(MAX_POINTS);
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned WEIGHT_W   = 17;
	localparam int unsigned PROD_W     = SAMPLE_W + WEIGHT_W + 1;
	localparam int unsigned ACC_W      = 62;
	localparam int unsigned OUT_W      = 48;
	localparam int unsigned FRAC_DROP  = 16;
	localparam int unsigned ADDR_W     = 3;
	localparam int unsigned DATA_W     = 32;

	localparam logic [ADDR_W-1:0] REG_POINT_COUNT = 3'd0;
	localparam logic [CNT_W-1:0]  COUNT_RESET     = 13'd7;
	localparam logic [CNT_W-1:0]  COUNT_MIN       = 13'd2;
	localparam logic [CNT_W-1:0]  COUNT_MAX       = CNT_W'(MAX_POINTS);

	typedef logic [WEIGHT_W-1:0] weight_t;

	// The weight for run length n and clamped end distance k (0..3, 3 means inner).
	function automatic weight_t weight_for(input logic [CNT_W-1:0] n, input logic [1:0] k);
		weight_t w;
		w = 17'd65536;
		case (n)
			13'd2: w = 17'd32768;
			13'd3: w = (k == 2'd0) ? 17'd21845 : 17'd87381;
			13'd4: w = (k == 2'd0) ? 17'd24576 : 17'd73728;
			13'd5: begin
				case (k)
					2'd0:    w = 17'd20389;
					2'd1:    w = 17'd93207;
					default: w = 17'd34953;
				endcase
			end
			13'd6: begin
				case (k)
					2'd0:    w = 17'd21618;
					2'd1:    w = 17'd85333;
					default: w = 17'd56889;
				endcase
			end
			default: begin
				case (k)
					2'd0:    w = 17'd24576;
					2'd1:    w = 17'd76459;
					2'd2:    w = 17'd62805;
					default: w = 17'd65536;
				endcase
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- src/newton_cotes_quadrature_accumulator.sv -----
// Top level of the Newton-Cotes quadrature accumulator: weight lookup, multiply and accumulate.
// Depends on nca_pkg for sizes, register addresses and the weight tables.
//
//   channel    | handshake                       | payload
//   -----------+---------------------------------+---------------------------
//   sample     | sample_valid / sample_ready     | sample   (32b signed)
//   integral   | integral_valid / integral_ready | integral (48b signed)
//   config     | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One item is accepted per cycle while the pipeline is not stalled. Each item passes a
// weight-select stage, a multiply stage and an accumulate stage; the sum of a run is offered
// when its last item leaves the accumulate stage. Reset sets the count to seven and clears the
// position, the accumulator and all valid flags. The pipeline stalls only when the final item
// of a run reaches the accumulator while an earlier sum still waits on the output.
`default_nettype none
module newton_cotes_quadrature_accumulator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [nca_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [nca_pkg::DATA_W-1:0]      pwdata,
	output logic      [nca_pkg::DATA_W-1:0]      prdata,
	output logic                                 pready,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire logic signed [nca_pkg::SAMPLE_W-1:0] sample,
	output logic                                 integral_valid,
	input  wire logic                            integral_ready,
	output logic signed [nca_pkg::OUT_W-1:0]     integral
);
	import nca_pkg::*;

	logic [CNT_W-1:0]        point_count_q;
	logic [POS_W-1:0]        position_q;
	logic signed [ACC_W-1:0] acc_q;

	logic                       v_s1, last_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	weight_t                    weight_s1;
	logic                       v_s2, last_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       out_valid_q;
	logic signed [OUT_W-1:0]    integral_q;

	logic [CNT_W-1:0]        n_eff;
	logic [POS_W-1:0]        n_m1;
	logic [POS_W-1:0]        end_dist;
	logic [POS_W-1:0]        k_full;
	logic [1:0]              k_sel;
	logic                    last_in;
	logic                    advance;
	logic                    accept;
	logic                    cfg_wr;
	logic signed [ACC_W-1:0] acc_sum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_POINT_COUNT[ADDR_W-1:2]);
	assign prdata = (paddr[ADDR_W-1:2] == REG_POINT_COUNT[ADDR_W-1:2]) ?
		{{(DATA_W-CNT_W){1'b0}}, point_count_q} : '0;

	assign advance      = !(v_s2 && last_s2 && out_valid_q && !integral_ready);
	assign sample_ready = advance;
	assign accept       = sample_valid && advance;

	always_comb begin
		if (point_count_q < COUNT_MIN) begin
			n_eff = COUNT_MIN;
		end else if (point_count_q > COUNT_MAX) begin
			n_eff = COUNT_MAX;
		end else begin
			n_eff = point_count_q;
		end
		n_m1     = POS_W'(n_eff - 1'b1);
		last_in  = (position_q >= n_m1);
		end_dist = last_in ? '0 : (n_m1 - position_q);
		k_full   = (position_q < end_dist) ? position_q : end_dist;
		k_sel    = (k_full > POS_W'(3)) ? 2'd3 : k_full[1:0];
	end

	assign acc_sum = acc_q + ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			point_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			acc_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && v_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (integral_valid && integral_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (accept) begin
					position_q <= last_in ? '0 : position_q + 1'b1;
				end
				v_s1 <= accept;
				v_s2 <= v_s1;
				if (v_s2) begin
					acc_q <= last_s2 ? '0 : acc_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (accept) begin
				sample_s1 <= sample;
				weight_s1 <= weight_for(n_eff, k_sel);
				last_s1   <= last_in;
			end
			prod_s2 <= sample_s1 * $signed({1'b0, weight_s1});
			last_s2 <= last_s1;
			if (v_s2 && last_s2) begin
				integral_q <= OUT_W'(acc_sum >>> FRAC_DROP);
			end
		end
	end

	assign integral_valid = out_valid_q;
	assign integral       = integral_q;

endmodule
`default_nettype wire
